/* sv/auto_ranging_light_mapper_assert.svh */
// Assertion macros for the auto-ranging light mapper.
`ifndef AUTO_RANGING_LIGHT_MAPPER_ASSERT_SVH
`define AUTO_RANGING_LIGHT_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define ARLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ARLM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ARLM_ASSERT(lbl, prop, msg)
`define ARLM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/arlm_pkg.sv */
// Shared constants and types for the auto-ranging light mapper.
`default_nettype none
package arlm_pkg;

  localparam int unsigned WINDOW_LENGTH_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF   = 10;
  localparam int unsigned WINDOW_PRESET_DEF = 600;

  localparam int unsigned MAP_BITS = 8;   // width of the mapped outputs
  localparam logic [MAP_BITS-1:0] DUTY_FULL = 8'd255;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_BAND  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SERVO_LOW  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SERVO_HIGH = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SERVO_REST = 2'd3;

  localparam logic [9:0] DEAD_BAND_RST  = 10'd10;
  localparam logic [7:0] SERVO_LOW_RST  = 8'd20;
  localparam logic [7:0] SERVO_HIGH_RST = 8'd160;
  localparam logic [7:0] SERVO_REST_RST = 8'd90;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_BOUND,
    ST_BLUE_GO,
    ST_BLUE_WAIT,
    ST_SERVO_GO,
    ST_SERVO_WAIT,
    ST_DONE
  } arlm_state_e;

endpackage
`default_nettype wire

/* sv/arlm_window.sv */
// Circular sample window with running sum.
`default_nettype none
module arlm_window #(
  parameter int unsigned WINDOW_LENGTH = 10,
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned WINDOW_PRESET = 600,
  parameter int unsigned SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_LENGTH)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SUM_BITS-1:0]    sum_o
);
  localparam int unsigned SLOT_BITS = $clog2(WINDOW_LENGTH);
  localparam int unsigned PRESET_M  = WINDOW_PRESET % (2 ** SAMPLE_BITS);
  localparam int unsigned SUM_RST   = WINDOW_LENGTH * PRESET_M;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_LENGTH - 1);

  logic [SAMPLE_BITS-1:0] win_q [WINDOW_LENGTH];
  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;

  always_comb begin
    sum_d  = sum_q - SUM_BITS'(win_q[slot_q]) + SUM_BITS'(sample_i);
    slot_d = (slot_q >= LAST_SLOT) ? '0 : slot_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= SAMPLE_BITS'(PRESET_M);
      end
      slot_q <= '0;
      sum_q  <= SUM_BITS'(SUM_RST);
    end else if (push_i) begin
      win_q[slot_q] <= sample_i;
      slot_q        <= slot_d;
      sum_q         <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

/* sv/arlm_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module arlm_divider #(
  parameter int unsigned QUOT_BITS = 10,
  parameter int unsigned NUM_BITS  = QUOT_BITS + 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [NUM_BITS-1:0]  num_i,   // num_i >> QUOT_BITS must be below den_i
  input  wire logic [QUOT_BITS-1:0] den_i,
  output logic                      done_o,
  output logic      [QUOT_BITS-1:0] quot_o
);
  localparam int unsigned CNT_BITS = $clog2(QUOT_BITS + 1);

  logic [QUOT_BITS-1:0] rem_q, rem_d;
  logic [QUOT_BITS-1:0] low_q, low_d;
  logic [QUOT_BITS-1:0] quot_q, quot_d;
  logic [QUOT_BITS-1:0] den_q, den_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [QUOT_BITS:0]   trial;
  logic [QUOT_BITS:0]   diff;

  always_comb begin
    trial  = {rem_q, low_q[QUOT_BITS-1]};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = QUOT_BITS'(num_i[NUM_BITS-1:QUOT_BITS]);
      low_d  = num_i[QUOT_BITS-1:0];
      quot_d = '0;
      den_d  = den_i;
      cnt_d  = CNT_BITS'(QUOT_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial subtract; a borrow keeps the partial remainder
      if (!diff[QUOT_BITS]) begin
        rem_d = diff[QUOT_BITS-1:0];
      end else begin
        rem_d = trial[QUOT_BITS-1:0];
      end
      low_d  = low_q << 1;
      quot_d = {quot_q[QUOT_BITS-2:0], ~diff[QUOT_BITS]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

/* sv/auto_ranging_light_mapper.sv */
// Top level of the auto-ranging light mapper: sequencer, bounds and output register.
//
//   channel   | dir | handshake          | payload
//   s_axis    | in  | tvalid / tready    | light_sample
//   m_axis    | out | tvalid / tready    | blue, red, servo, average, low, high
//   cfg       | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A new sample is accepted only once the previous one has gone back to idle;
// each sample runs through the one shared divider in turn: average, blue map,
// servo map, with the two maps skipped when the spread lies in the dead band.
// Reset preloads the window and clears the bounds; no clearing pass.
// A result waiting in the output register does not block a new request; the
// sequencer stalls in its last step only if the previous result is still held.
`default_nettype none
module auto_ranging_light_mapper #(
  parameter int unsigned WINDOW_LENGTH = arlm_pkg::WINDOW_LENGTH_DEF,
  parameter int unsigned SAMPLE_BITS   = arlm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned WINDOW_PRESET = arlm_pkg::WINDOW_PRESET_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // light_sample [9:0], zero padding [15:10]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [15:0]                        s_axis_tdata,
  // blue_duty [7:0], red_duty [15:8], servo_angle [23:16], average_level [33:24],
  // low_bound [43:34], high_bound [53:44], zero padding [55:54]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [55:0]                             m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [arlm_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [arlm_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import arlm_pkg::*;
  `include "auto_ranging_light_mapper_assert.svh"

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned NUM_BITS = SB + MAP_BITS;
  localparam int unsigned SUM_BITS = SB + $clog2(WINDOW_LENGTH);
  localparam int unsigned CMP_BITS = (SB > 10) ? SB : 10;

  // configuration registers
  logic [9:0] dead_band_q;
  logic [7:0] servo_low_q, servo_high_q, servo_rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q  <= DEAD_BAND_RST;
      servo_low_q  <= SERVO_LOW_RST;
      servo_high_q <= SERVO_HIGH_RST;
      servo_rest_q <= SERVO_REST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEAD_BAND:  dead_band_q  <= cfg_data_i;
        REG_SERVO_LOW:  servo_low_q  <= cfg_data_i[7:0];
        REG_SERVO_HIGH: servo_high_q <= cfg_data_i[7:0];
        REG_SERVO_REST: servo_rest_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  arlm_state_e state_q, state_d;

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // window and running sum
  logic [SUM_BITS-1:0] win_sum;

  arlm_window #(
    .WINDOW_LENGTH(WINDOW_LENGTH),
    .SAMPLE_BITS  (SB),
    .WINDOW_PRESET(WINDOW_PRESET),
    .SUM_BITS     (SUM_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_accept),
    .sample_i(SB'(s_axis_tdata[9:0])),
    .sum_o   (win_sum)
  );

  // datapath registers
  logic [SB-1:0]       avg_q, low_q, high_q, off_q, span_q;
  logic [MAP_BITS-1:0] blue_q, red_q, servo_q;

  // shared divider
  logic                div_start, div_done;
  logic [NUM_BITS-1:0] div_num;
  logic [SB-1:0]       div_den, div_quot;
  logic [MAP_BITS-1:0] map_mult;
  logic [NUM_BITS-1:0] map_prod;

  arlm_divider #(
    .QUOT_BITS(SB),
    .NUM_BITS (NUM_BITS)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // servo map direction and step size
  logic                servo_down;
  logic [MAP_BITS-1:0] servo_mag;
  assign servo_down = servo_high_q < servo_low_q;
  assign servo_mag  = servo_down ? (servo_low_q - servo_high_q)
                                 : (servo_high_q - servo_low_q);

  assign map_prod = NUM_BITS'(off_q) * NUM_BITS'(map_mult);

  // widening against the fresh average
  logic [SB-1:0] low_wide, high_wide;
  assign high_wide = (div_quot > high_q) ? div_quot : high_q;
  assign low_wide  = (div_quot < low_q)  ? div_quot : low_q;

  // spread after widening; a borrow means crossed bounds, treated as inside
  logic [SB:0] spread;
  logic        in_dead_band;
  assign spread       = {1'b0, high_q} - {1'b0, low_q};
  assign in_dead_band = spread[SB] ||
                        (CMP_BITS'(spread[SB-1:0]) <= CMP_BITS'(dead_band_q));

  // decay after the outputs are formed
  logic [SB-1:0] low_dec, high_dec;
  assign low_dec  = (high_q > low_q) ? low_q + 1'b1  : low_q;
  assign high_dec = (high_q > low_q) ? high_q - 1'b1 : high_q;

  logic out_load;
  assign out_load = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (s_accept) state_d = ST_AVG_GO;
      ST_AVG_GO:     state_d = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (div_done) state_d = ST_BOUND;
      ST_BOUND:      state_d = in_dead_band ? ST_DONE : ST_BLUE_GO;
      ST_BLUE_GO:    state_d = ST_BLUE_WAIT;
      ST_BLUE_WAIT:  if (div_done) state_d = ST_SERVO_GO;
      ST_SERVO_GO:   state_d = ST_SERVO_WAIT;
      ST_SERVO_WAIT: if (div_done) state_d = ST_DONE;
      ST_DONE:       if (out_load) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_num       = NUM_BITS'(win_sum);
    div_den       = SB'(WINDOW_LENGTH);
    map_mult      = DUTY_FULL;
    case (state_q)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_AVG_GO:   div_start = 1'b1;
      ST_BLUE_GO: begin
        div_start = 1'b1;
        div_num   = map_prod;
        div_den   = span_q;
      end
      ST_SERVO_GO: begin
        div_start = 1'b1;
        map_mult  = servo_mag;
        div_num   = map_prod;
        div_den   = span_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      low_q   <= '0;
      high_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_AVG_WAIT && div_done) begin
        low_q  <= low_wide;
        high_q <= high_wide;
      end else if (out_load) begin
        low_q  <= low_dec;
        high_q <= high_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AVG_WAIT: if (div_done) avg_q <= div_quot;
      ST_BOUND: begin
        off_q   <= avg_q - low_q;
        span_q  <= spread[SB-1:0];
        blue_q  <= '0;
        red_q   <= '0;
        servo_q <= servo_rest_q;
      end
      ST_BLUE_WAIT: begin
        if (div_done) begin
          blue_q <= div_quot[MAP_BITS-1:0];
          red_q  <= DUTY_FULL - div_quot[MAP_BITS-1:0];
        end
      end
      ST_SERVO_WAIT: begin
        if (div_done) begin
          servo_q <= servo_down ? servo_low_q - div_quot[MAP_BITS-1:0]
                                : servo_low_q + div_quot[MAP_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  logic        m_valid_q, m_valid_d;
  logic [55:0] m_data_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {2'b00, 10'(high_dec), 10'(low_dec), 10'(avg_q),
                   servo_q, red_q, blue_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  `ARLM_ASSERT(a_accept_starts, s_accept |=> (state_q == ST_AVG_GO), "accept did not start")
  `ARLM_ASSERT(a_div_done_wait, div_done |-> (state_q == ST_AVG_WAIT || state_q == ST_BLUE_WAIT || state_q == ST_SERVO_WAIT), "divider result unexpected")
  `ARLM_ASSERT(a_duty_pair, m_axis_tvalid |-> ((m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[15:8] == 8'd0) || ({1'b0, m_axis_tdata[7:0]} + {1'b0, m_axis_tdata[15:8]} == 9'd255)), "duty pair mismatch")
  `ARLM_ASSERT(a_bounds_order, (state_q == ST_IDLE) |-> ({1'b0, low_q} <= {1'b0, high_q} + 1'b1), "bounds crossed by more than one")

endmodule
`default_nettype wire
